### hw/rtl/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MUL,
      ST_DONE
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;   // capture a new item and set up the base reduction pass
      logic step;   // one multiplier bit through both lanes
      logic last;   // final bit of a pass: commit lane results, begin next pass
      logic emit;   // present the result for one cycle
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic trivial;    // zero exponent or zero modulus: no passes needed
      logic exp_last;   // current exponent bit is the highest set one
   } dp_status_type;

endpackage

`default_nettype wire

### hw/rtl/modular_exponentiation_top.sv
`default_nettype none

// Modular exponentiation, base ** exponent mod modulus, by right-to-left
// square-and-multiply. An item is taken when start is high and busy is low;
// the result appears on rsp_power_residue for exactly one cycle with rsp_valid
// high, and must be captured then, since the block cannot be stalled. A zero
// exponent gives 1 (even for modulus 1); a zero modulus gives 0; either case
// skips the passes. Otherwise the run time is set by the shared multiply-reduce
// lanes, which handle one multiplier bit per cycle: one pass reduces the base,
// then one pass per exponent bit, up to the highest set one, forms the square
// and the conditional product side by side. busy is high from the accepting
// edge until the result cycle and low in it, so one item is in flight at a time
// and the next can be taken as the result leaves.
module modular_exponentiation_top #(
   parameter int OPERAND_WIDTH = 31
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [OPERAND_WIDTH-1:0] req_base,
   input  wire logic [OPERAND_WIDTH-1:0] req_exponent,
   input  wire logic [OPERAND_WIDTH-1:0] req_modulus,
   output logic                          rsp_valid,
   output logic [OPERAND_WIDTH-1:0]      rsp_power_residue
);

   mexp_pkg::dp_cmd_type    cmd;
   mexp_pkg::dp_status_type status;

   mexp_ctrl #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   mexp_datapath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_base          (req_base),
      .req_exponent      (req_exponent),
      .req_modulus       (req_modulus),
      .rsp_valid         (rsp_valid),
      .rsp_power_residue (rsp_power_residue)
   );

endmodule

`default_nettype wire

### hw/rtl/mexp_datapath.sv
`default_nettype none

module mexp_datapath #(
   parameter int OPERAND_WIDTH = 31
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire mexp_pkg::dp_cmd_type         cmd,
   output mexp_pkg::dp_status_type           status,
   input  wire logic [OPERAND_WIDTH-1:0]     req_base,
   input  wire logic [OPERAND_WIDTH-1:0]     req_exponent,
   input  wire logic [OPERAND_WIDTH-1:0]     req_modulus,
   output logic                              rsp_valid,
   output logic [OPERAND_WIDTH-1:0]          rsp_power_residue
);

   localparam int W = OPERAND_WIDTH;

   // (a + b) mod m for a, b < m
   function automatic logic [W-1:0] add_mod(input logic [W-1:0] a,
                                            input logic [W-1:0] b,
                                            input logic [W-1:0] m);
      logic [W:0] s;
      logic [W:0] d;
      begin
         s = {1'b0, a} + {1'b0, b};
         d = s - {1'b0, m};
         add_mod = (s >= {1'b0, m}) ? d[W-1:0] : s[W-1:0];
      end
   endfunction

   logic [W-1:0] m_ff, m_in;
   logic [W-1:0] e_ff, e_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] pa_ff, pa_in;     // lane A partial: acc * sq
   logic [W-1:0] pb_ff, pb_in;     // lane B partial: xb * y
   logic [W-1:0] xb_ff, xb_in;     // lane B multiplicand
   logic [W-1:0] y_ff, y_in;       // multiplier bits, MSB first
   logic         zero_exp_ff, zero_exp_in;
   logic         zero_mod_ff, zero_mod_in;
   logic         valid_ff, valid_in;
   logic [W-1:0] res_ff, res_in;

   logic [W-1:0] pa_step;
   logic [W-1:0] pb_step;
   logic         ybit;

   // one interleaved multiply-reduce bit in each lane
   always_comb begin
      ybit    = y_ff[W-1];
      pa_step = add_mod(add_mod(pa_ff, pa_ff, m_ff), ybit ? acc_ff : '0, m_ff);
      pb_step = add_mod(add_mod(pb_ff, pb_ff, m_ff), ybit ? xb_ff : '0, m_ff);
   end

   // next-state of the datapath registers
   always_comb begin
      m_in        = m_ff;
      e_in        = e_ff;
      acc_in      = acc_ff;
      pa_in       = pa_ff;
      pb_in       = pb_ff;
      xb_in       = xb_ff;
      y_in        = y_ff;
      zero_exp_in = zero_exp_ff;
      zero_mod_in = zero_mod_ff;
      valid_in    = 1'b0;
      res_in      = res_ff;

      if (cmd.load) begin
         m_in        = req_modulus;
         e_in        = req_exponent;
         acc_in      = (req_modulus == W'(1)) ? '0 : W'(1);
         pa_in       = '0;
         pb_in       = '0;
         xb_in       = W'(1);          // reduction pass: base * 1 mod m
         y_in        = req_base;
         zero_exp_in = (req_exponent == '0);
         zero_mod_in = (req_modulus == '0);
      end else if (cmd.step) begin
         if (cmd.last) begin
            // lane B holds the new square; lane A the product when the bit is set
            pa_in = '0;
            pb_in = '0;
            xb_in = pb_step;
            y_in  = pb_step;
         end else begin
            pa_in = pa_step;
            pb_in = pb_step;
            y_in  = {y_ff[W-2:0], 1'b0};
         end
      end

      if (cmd.emit) begin
         valid_in = 1'b1;
         if (zero_mod_ff) begin
            res_in = '0;
         end else if (zero_exp_ff) begin
            res_in = W'(1);
         end else begin
            res_in = acc_ff;
         end
      end
   end

   // exponent bit commit, kept apart from the reduction pass
   logic mul_commit;
   logic mul_pass_ff, mul_pass_in;

   always_comb begin
      mul_commit  = cmd.step && cmd.last && mul_pass_ff;
      mul_pass_in = mul_pass_ff;
      if (cmd.load) begin
         mul_pass_in = 1'b0;
      end else if (cmd.step && cmd.last) begin
         mul_pass_in = 1'b1;
      end
   end

   logic [W-1:0] acc_fin;
   logic [W-1:0] e_fin;

   always_comb begin
      acc_fin = acc_in;
      e_fin   = e_in;
      if (mul_commit) begin
         if (e_ff[0]) begin
            acc_fin = pa_step;
         end
         e_fin = {1'b0, e_ff[W-1:1]};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         mul_pass_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         mul_pass_ff <= mul_pass_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      e_ff        <= e_fin;
      acc_ff      <= acc_fin;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      xb_ff       <= xb_in;
      y_ff        <= y_in;
      zero_exp_ff <= zero_exp_in;
      zero_mod_ff <= zero_mod_in;
      res_ff      <= res_in;
   end

   always_comb begin
      status.trivial  = zero_exp_ff | zero_mod_ff;
      status.exp_last = (e_ff[W-1:1] == '0) && mul_pass_ff;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_power_residue = res_ff;

endmodule

`default_nettype wire

### hw/rtl/mexp_ctrl.sv
`default_nettype none

module mexp_ctrl #(
   parameter int OPERAND_WIDTH = 31
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire mexp_pkg::dp_status_type  status,
   output mexp_pkg::dp_cmd_type          cmd
);

   localparam int CNT_W = $clog2(OPERAND_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_WIDTH - 1);

   mexp_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   // state and bit counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mexp_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      busy     = 1'b1;

      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = mexp_pkg::ST_REDUCE;
            end
         end
         mexp_pkg::ST_REDUCE: begin
            if (status.trivial) begin
               state_in = mexp_pkg::ST_DONE;
            end else begin
               cmd.step = 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  cmd.last = 1'b1;
                  cnt_in   = '0;
                  state_in = mexp_pkg::ST_MUL;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         mexp_pkg::ST_MUL: begin
            cmd.step = 1'b1;
            if (cnt_ff == CNT_LAST) begin
               cmd.last = 1'b1;
               cnt_in   = '0;
               if (status.exp_last) begin
                  state_in = mexp_pkg::ST_DONE;
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         mexp_pkg::ST_DONE: begin
            cmd.emit = 1'b1;
            state_in = mexp_pkg::ST_IDLE;
         end
         default: begin
            state_in = mexp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire
